// ----- hw/rtl/tile_video_timing_and_pixel_serializer_defines.svh -----
// assertion macros for the tile video timing and pixel serializer
`ifndef TILE_VIDEO_TIMING_AND_PIXEL_SERIALIZER_DEFINES_SVH
`define TILE_VIDEO_TIMING_AND_PIXEL_SERIALIZER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TVTPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TVTPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TVTPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TVTPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/tvtps_pkg.sv -----
// shared types, constants and the pixel pick function
package tvtps_pkg;

   localparam logic [8:0] H_WRAP  = 9'h1A0;
   localparam logic [8:0] H_START = 9'h020;
   localparam logic [8:0] V_START = 9'h0F8;

   localparam logic [2:0] PHASE_FIX   = 3'd1;
   localparam logic [2:0] PHASE_ALOAD = 3'd5;
   localparam logic [2:0] PHASE_SHIFT = 3'd7;
   localparam logic [2:0] SCROLL_HOLD = 3'd7;

   typedef struct packed {
      logic       reset_synced;
      logic       m6_rise;
      logic       colour_hold;
      logic [2:0] fix_select;
      logic [8:0] h;
      logic       clock_m12;
      logic       clock_m6;
      logic       hblank_early;
      logic       hblank_late;
      logic       vblank_n;
   } tim_type;

   typedef struct packed {
      logic [11:0] layer_a_pixel;
      logic [11:0] layer_b_pixel;
      logic [7:0]  fix_pixel;
      logic        fix_opaque;
   } ser_type;

   typedef struct packed {
      logic        clock_m12;
      logic        clock_m6;
      logic        hblank_early;
      logic        hblank_late;
      logic        vblank_n;
      logic [11:0] layer_a_pixel;
      logic [11:0] layer_b_pixel;
      logic [7:0]  fix_pixel;
      logic        fix_opaque;
   } rsp_type;

   function automatic logic [3:0] pick_pixel(input logic [31:0] word, input logic [2:0] sel);
      logic [3:0] r;
      r = '0;
      for (int p = 0; p < 4; p++) begin
         r[p] = word[{2'(p), sel}];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/tvtps_timing.sv -----
// reset sync, clock divider, raster counters and blank flags
module tvtps_timing (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               mclk,
   input  logic               nres,
   output tvtps_pkg::tim_type tim
);
   import tvtps_pkg::*;

   logic       rs_ff, rs_in;
   logic [2:0] div_ff, div_in;
   logic [2:0] cp_ff, cp_in;
   logic [2:0] last_ff, last_in;
   logic [8:0] h_ff, h_in;
   logic [8:0] v_ff, v_in;
   logic       fixph_ff, fixph_in;
   logic       hbe_ff, hbe_in;
   logic       trig_ff, trig_in;
   logic       hbl_ff, hbl_in;
   logic       vbl_ff, vbl_in;
   logic       ptrig_ff, pv4_ff, ph1_ff;
   logic       rise, m6_rise, z99, row_last;
   logic [8:0] h_inc;
   logic [9:0] v_inc;

   always_comb begin
      rise = !last_ff[0] && mclk;
      if (!nres) begin
         rs_in = 1'b0;
      end else if (rise) begin
         rs_in = 1'b1;
      end else begin
         rs_in = rs_ff;
      end

      div_in = div_ff;
      cp_in  = cp_ff;
      if (!rs_in) begin
         div_in = '0;
         cp_in  = '1;
      end else if (rise) begin
         cp_in  = {div_ff[1], ~div_ff[1], ~div_ff[0]};
         div_in = div_ff + 3'd1;
      end
      m6_rise = !last_ff[2] && cp_in[1];

      h_inc = h_ff + 9'd1;
      v_inc = {1'b0, v_ff} + 10'd1;
      h_in  = h_ff;
      v_in  = v_ff;
      if (!rs_in) begin
         h_in = '0;
         v_in = '0;
      end else if (m6_rise) begin
         if (h_inc == H_WRAP) begin
            h_in = H_START;
            v_in = v_inc[9] ? V_START : v_inc[8:0];
         end else begin
            h_in = h_inc;
         end
      end

      fixph_in = fixph_ff;
      if (!rs_in) begin
         fixph_in = 1'b0;
      end else if (!ph1_ff && h_in[1]) begin
         fixph_in = h_in[2];
      end

      z99      = (h_in[4:1] == 4'hF);
      row_last = z99 && h_in[8] && h_in[7];
      hbe_in   = hbe_ff;
      trig_in  = trig_ff;
      hbl_in   = hbl_ff;
      vbl_in   = vbl_ff;
      if (!rs_in) begin
         hbe_in  = 1'b0;
         trig_in = 1'b0;
         hbl_in  = 1'b0;
         vbl_in  = 1'b0;
      end else begin
         if (m6_rise) begin
            hbe_in  = !row_last && (hbe_ff || (z99 && h_in[6]));
            trig_in = h_in[0] && h_in[3] && !(h_in[2] || h_in[1]);
         end
         if (!ptrig_ff && trig_in) begin
            hbl_in = hbe_in;
         end
         if (!pv4_ff && v_in[4]) begin
            vbl_in = v_in[7] && v_in[6] && v_in[5];
         end
      end

      last_in = {cp_in[1], cp_in[0], mclk};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= 1'b0;
         div_ff   <= '0;
         cp_ff    <= '1;
         last_ff  <= '0;
         h_ff     <= '0;
         v_ff     <= '0;
         fixph_ff <= 1'b0;
         hbe_ff   <= 1'b0;
         trig_ff  <= 1'b0;
         hbl_ff   <= 1'b0;
         vbl_ff   <= 1'b0;
         ptrig_ff <= 1'b0;
         pv4_ff   <= 1'b0;
         ph1_ff   <= 1'b0;
      end else if (accept) begin
         rs_ff    <= rs_in;
         div_ff   <= div_in;
         cp_ff    <= cp_in;
         last_ff  <= last_in;
         h_ff     <= h_in;
         v_ff     <= v_in;
         fixph_ff <= fixph_in;
         hbe_ff   <= hbe_in;
         trig_ff  <= trig_in;
         hbl_ff   <= hbl_in;
         vbl_ff   <= vbl_in;
         ptrig_ff <= trig_in;
         pv4_ff   <= v_in[4];
         ph1_ff   <= h_in[1];
      end
   end

   always_comb begin
      tim.reset_synced = rs_in;
      tim.m6_rise      = m6_rise;
      tim.colour_hold  = cp_in[2];
      tim.fix_select   = ~{fixph_in, ~h_in[1], h_in[0]};
      tim.h            = h_in;
      tim.clock_m12    = cp_in[0];
      tim.clock_m6     = cp_in[1];
      tim.hblank_early = hbe_in;
      tim.hblank_late  = hbl_in;
      tim.vblank_n     = ~vbl_in;
   end

endmodule

// ----- hw/rtl/tvtps_serializer.sv -----
// rom delay stages, per-plane pixel pick and colour output registers
module tvtps_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  tvtps_pkg::tim_type tim,
   input  logic [2:0]         za,
   input  logic [2:0]         zb,
   input  logic [31:0]        rom,
   input  logic [7:0]         attr,
   output tvtps_pkg::ser_type ser
);
   import tvtps_pkg::*;

   logic [31:0] apat0_ff, apat0_in, apat1_ff, apat1_in, apat2_ff, apat2_in;
   logic [7:0]  aatt0_ff, aatt0_in, aatt1_ff, aatt1_in;
   logic [3:0]  aatt2_ff, aatt2_in;
   logic [31:0] bpat0_ff, bpat0_in, bpat1_ff, bpat1_in;
   logic [7:0]  batt0_ff, batt0_in;
   logic [3:0]  batt1_ff, batt1_in;
   logic [31:0] fpat_ff, fpat_in;
   logic [3:0]  fatt_ff, fatt_in;
   logic [4:0]  eh_ff, eh_in;
   logic [11:0] c0_ff, c0_in, c1_ff, c1_in;
   logic [7:0]  c2_ff, c2_in;
   logic        s_fix, s_aload, s_shift, s_a, s_b;
   logic [3:0]  fixc, lac, lbc;

   always_comb begin
      s_fix   = (tim.h[2:0] != PHASE_FIX);
      s_aload = (tim.h[2:0] != PHASE_ALOAD);
      s_shift = (tim.h[2:0] != PHASE_SHIFT);
      s_a     = (za != SCROLL_HOLD);
      s_b     = (zb != SCROLL_HOLD);

      apat0_in = apat0_ff;
      apat1_in = apat1_ff;
      apat2_in = apat2_ff;
      aatt0_in = aatt0_ff;
      aatt1_in = aatt1_ff;
      aatt2_in = aatt2_ff;
      bpat0_in = bpat0_ff;
      bpat1_in = bpat1_ff;
      batt0_in = batt0_ff;
      batt1_in = batt1_ff;
      fpat_in  = fpat_ff;
      fatt_in  = fatt_ff;
      eh_in    = eh_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;

      if (tim.m6_rise) begin
         if (!eh_ff[1] && s_aload) begin
            aatt0_in = attr;
            apat0_in = rom;
         end
         if (!eh_ff[2] && s_shift) begin
            apat1_in = apat0_in;
            aatt1_in = aatt0_in;
            batt0_in = attr;
            bpat0_in = rom;
         end
         if (!eh_ff[3] && s_a) begin
            c0_in[11:8] = aatt1_in[3:0];
            aatt2_in    = aatt1_in[7:4];
            apat2_in    = apat1_in;
         end
         if (!eh_ff[4] && s_b) begin
            c1_in[11:8] = batt0_in[3:0];
            batt1_in    = batt0_in[7:4];
            bpat1_in    = bpat0_in;
         end
         if (!eh_ff[0] && s_fix) begin
            fatt_in = attr[7:4];
            fpat_in = rom;
         end
         eh_in = {s_b, s_a, s_shift, s_aload, s_fix};
      end

      fixc = pick_pixel(fpat_in, tim.fix_select);
      lac  = pick_pixel(apat2_in, ~za);
      lbc  = pick_pixel(bpat1_in, ~zb);
      if (!tim.colour_hold) begin
         c1_in[7:0] = {batt1_in, lbc};
         c0_in[7:0] = {aatt2_in, lac};
         c2_in      = {fatt_in, fixc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apat0_ff <= '0;
         apat1_ff <= '0;
         apat2_ff <= '0;
         aatt0_ff <= '0;
         aatt1_ff <= '0;
         aatt2_ff <= '0;
         bpat0_ff <= '0;
         bpat1_ff <= '0;
         batt0_ff <= '0;
         batt1_ff <= '0;
         fpat_ff  <= '0;
         fatt_ff  <= '0;
         eh_ff    <= '0;
         c0_ff    <= '0;
         c1_ff    <= '0;
         c2_ff    <= '0;
      end else if (accept) begin
         apat0_ff <= apat0_in;
         apat1_ff <= apat1_in;
         apat2_ff <= apat2_in;
         aatt0_ff <= aatt0_in;
         aatt1_ff <= aatt1_in;
         aatt2_ff <= aatt2_in;
         bpat0_ff <= bpat0_in;
         bpat1_ff <= bpat1_in;
         batt0_ff <= batt0_in;
         batt1_ff <= batt1_in;
         fpat_ff  <= fpat_in;
         fatt_ff  <= fatt_in;
         eh_ff    <= eh_in;
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
      end
   end

   always_comb begin
      ser.layer_a_pixel = c0_in;
      ser.layer_b_pixel = c1_in;
      ser.fix_pixel     = c2_in;
      ser.fix_opaque    = (fixc != 4'h0);
   end

endmodule

// ----- hw/rtl/tvtps_out_skid.sv -----
// result register with one skid entry
module tvtps_out_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tvtps_pkg::rsp_type push_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output tvtps_pkg::rsp_type rsp_data,
   output logic               full
);
   import tvtps_pkg::*;

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;
   logic    take;

   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign full      = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

// ----- hw/rtl/tile_video_timing_and_pixel_serializer.sv -----
// top level: tile video timing generator and pixel serializer
// a result is held in the output register, or in the skid entry while the output waits
// throughput: one item per cycle while req_stall is low, set by the single pass from state to result register
// a two-entry result buffer lets one transfer in while a result waits
// synchronous reset returns the control state to its cleared values; result and skid data are not reset
module tile_video_timing_and_pixel_serializer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_master_clock_level,
   input  logic        req_reset_n,
   input  logic [2:0]  req_layer_a_fine_scroll,
   input  logic [2:0]  req_layer_b_fine_scroll,
   input  logic [31:0] req_rom_pixels,
   input  logic [7:0]  req_rom_attribute,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_clock_m12,
   output logic        rsp_clock_m6,
   output logic        rsp_hblank_early,
   output logic        rsp_hblank_late,
   output logic        rsp_vblank_n,
   output logic [11:0] rsp_layer_a_pixel,
   output logic [11:0] rsp_layer_b_pixel,
   output logic [7:0]  rsp_fix_pixel,
   output logic        rsp_fix_opaque
);
   import tvtps_pkg::*;

`include "tile_video_timing_and_pixel_serializer_defines.svh"

   logic    req_transfer;
   tim_type tim;
   ser_type ser;
   rsp_type result, rsp_data;

   assign req_transfer = req_valid && !req_stall;

   tvtps_timing u_timing (
      .clock  (clock),
      .reset  (reset),
      .accept (req_transfer),
      .mclk   (req_master_clock_level),
      .nres   (req_reset_n),
      .tim    (tim)
   );

   tvtps_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .accept (req_transfer),
      .tim    (tim),
      .za     (req_layer_a_fine_scroll),
      .zb     (req_layer_b_fine_scroll),
      .rom    (req_rom_pixels),
      .attr   (req_rom_attribute),
      .ser    (ser)
   );

   always_comb begin
      result.clock_m12     = tim.clock_m12;
      result.clock_m6      = tim.clock_m6;
      result.hblank_early  = tim.hblank_early;
      result.hblank_late   = tim.hblank_late;
      result.vblank_n      = tim.vblank_n;
      result.layer_a_pixel = ser.layer_a_pixel;
      result.layer_b_pixel = ser.layer_b_pixel;
      result.fix_pixel     = ser.fix_pixel;
      result.fix_opaque    = ser.fix_opaque;
   end

   tvtps_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (req_transfer),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (req_stall)
   );

   assign rsp_clock_m12     = rsp_data.clock_m12;
   assign rsp_clock_m6      = rsp_data.clock_m6;
   assign rsp_hblank_early  = rsp_data.hblank_early;
   assign rsp_hblank_late   = rsp_data.hblank_late;
   assign rsp_vblank_n      = rsp_data.vblank_n;
   assign rsp_layer_a_pixel = rsp_data.layer_a_pixel;
   assign rsp_layer_b_pixel = rsp_data.layer_b_pixel;
   assign rsp_fix_pixel     = rsp_data.fix_pixel;
   assign rsp_fix_opaque    = rsp_data.fix_opaque;

   // buffer full means a result is waiting at the port
   `TVTPS_ASSERT_IMP(a_stall_has_result, clock, reset, req_stall, rsp_valid)
   // every transfer leaves a result to show
   `TVTPS_ASSERT_NEXT(a_transfer_gives_result, clock, reset, req_transfer, rsp_valid)
   // horizontal counter wraps before the line end value
   `TVTPS_ASSERT_IMP(a_h_in_range, clock, reset, tim.reset_synced, tim.h != H_WRAP)

endmodule
